>>> hdl/dcsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsu_pkg
// Shared codes, types and word tables for the double-cell stack unit.
// ----------------------------------------------------------------------------
package dcsu_pkg;

  localparam int StackDepthDef = 256;
  localparam int CellBitsDef   = 64;
  localparam int ActW          = 5;
  localparam int CountW        = 9;
  localparam int SlotW         = 3;

  localparam logic [ActW-1:0] ACT_PUSH    = 5'd0;
  localparam logic [ActW-1:0] ACT_POP     = 5'd1;
  localparam logic [ActW-1:0] ACT_STOD    = 5'd2;
  localparam logic [ActW-1:0] ACT_DPLUS   = 5'd3;
  localparam logic [ActW-1:0] ACT_DMINUS  = 5'd4;
  localparam logic [ActW-1:0] ACT_DNEG    = 5'd5;
  localparam logic [ActW-1:0] ACT_DABS    = 5'd6;
  localparam logic [ActW-1:0] ACT_DMAX    = 5'd7;
  localparam logic [ActW-1:0] ACT_DMIN    = 5'd8;
  localparam logic [ActW-1:0] ACT_DLT     = 5'd9;
  localparam logic [ActW-1:0] ACT_DEQ     = 5'd10;
  localparam logic [ActW-1:0] ACT_2DROP   = 5'd11;
  localparam logic [ActW-1:0] ACT_2DUP    = 5'd12;
  localparam logic [ActW-1:0] ACT_2SWAP   = 5'd13;
  localparam logic [ActW-1:0] ACT_2OVER   = 5'd14;
  localparam logic [ActW-1:0] ACT_2ROT    = 5'd15;
  localparam logic [ActW-1:0] ACT_2TOR    = 5'd16;
  localparam logic [ActW-1:0] ACT_2RFROM  = 5'd17;
  localparam logic [ActW-1:0] ACT_2RFETCH = 5'd18;
  localparam logic [ActW-1:0] ACT_D0EQ    = 5'd19;
  localparam logic [ActW-1:0] ACT_D0LT    = 5'd20;
  localparam logic [ActW-1:0] ACT_D2MUL   = 5'd21;
  localparam logic [ActW-1:0] ACT_D2DIV   = 5'd22;

  typedef struct packed {
    logic take;
    logic check;
    logic load;
    logic exec;
    logic store;
    logic top;
    logic finish;
  } dcsu_cmd_t;

  typedef struct packed {
    logic skip;
    logic load_done;
    logic store_done;
    logic out_free;
  } dcsu_sts_t;

  // data cells consumed by a word
  function automatic logic [SlotW-1:0] need_of(input logic [ActW-1:0] act);
    logic [SlotW-1:0] n;
    case (act)
      ACT_PUSH, ACT_2RFROM, ACT_2RFETCH: n = 3'd0;
      ACT_POP, ACT_STOD: n = 3'd1;
      ACT_DPLUS, ACT_DMINUS, ACT_DMAX, ACT_DMIN, ACT_DLT, ACT_DEQ,
      ACT_2SWAP, ACT_2OVER: n = 3'd4;
      ACT_2ROT: n = 3'd6;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  // data cells produced by a word
  function automatic logic [SlotW-1:0] prod_of(input logic [ActW-1:0] act);
    logic [SlotW-1:0] n;
    case (act)
      ACT_PUSH, ACT_DLT, ACT_DEQ, ACT_D0EQ, ACT_D0LT: n = 3'd1;
      ACT_POP, ACT_2DROP, ACT_2TOR: n = 3'd0;
      ACT_2DUP, ACT_2SWAP: n = 3'd4;
      ACT_2OVER, ACT_2ROT: n = 3'd6;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

>>> hdl/double_cell_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_cell_stack_unit
// Forth double-number word unit with data and return stacks of cells.
// ----------------------------------------------------------------------------
// One word is processed at a time and yields one result transaction. A
// rejected or unused word skips the load, execute and store steps. Any
// other word reads its cells one per cycle through a stack memory read port
// and brings the last cell in, executes, then writes its result cells back
// one per cycle and commits the depths. The output register lets the next
// word be accepted while the previous result waits to be taken. A finished
// word holds in its last state until that previous result has been taken.
// Stacks need no clearing after reset; both depths start at zero.
module double_cell_stack_unit #(
  parameter int STACK_DEPTH = dcsu_pkg::StackDepthDef,
  parameter int CELL_BITS   = dcsu_pkg::CellBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dcsu_pkg::ActW-1:0]   action_i,
  input  logic signed [CELL_BITS-1:0] push_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [CELL_BITS-1:0] top_value_o,
  output logic                        error_flag_o,
  output logic [dcsu_pkg::CountW-1:0] data_count_o,
  output logic [dcsu_pkg::CountW-1:0] return_count_o
);

  dcsu_pkg::dcsu_cmd_t cmd;
  dcsu_pkg::dcsu_sts_t sts;

  dcsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dcsu_datapath #(
    .StackDepth (STACK_DEPTH),
    .CellBits   (CELL_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_value_o    (top_value_o),
    .error_flag_o   (error_flag_o),
    .data_count_o   (data_count_o),
    .return_count_o (return_count_o)
  );

endmodule

>>> hdl/dcsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsu_ctrl
// Sequencer: steps one word through check, load, execute, store and report.
// ----------------------------------------------------------------------------
module dcsu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output dcsu_pkg::dcsu_cmd_t cmd_o,
  input  dcsu_pkg::dcsu_sts_t sts_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_TOP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.skip ? S_TOP : S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        if (sts_i.load_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_STORE;
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        if (sts_i.store_done) state_d = S_TOP;
      end
      S_TOP: begin
        cmd_o.top = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        // hold until the output slot frees up
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/dcsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsu_datapath
// Stack memories, depth counters, operand and result cells, output register.
// ----------------------------------------------------------------------------
module dcsu_datapath #(
  parameter int StackDepth = dcsu_pkg::StackDepthDef,
  parameter int CellBits   = dcsu_pkg::CellBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dcsu_pkg::dcsu_cmd_t         cmd_i,
  output dcsu_pkg::dcsu_sts_t         sts_o,
  input  logic [dcsu_pkg::ActW-1:0]   action_i,
  input  logic signed [CellBits-1:0]  push_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [CellBits-1:0]  top_value_o,
  output logic                        error_flag_o,
  output logic [dcsu_pkg::CountW-1:0] data_count_o,
  output logic [dcsu_pkg::CountW-1:0] return_count_o
);

  localparam int DepW  = $clog2(StackDepth + 1);
  localparam int AddrW = $clog2(StackDepth);
  localparam int SW    = dcsu_pkg::SlotW;
  localparam int DW    = 2 * CellBits;

  logic [CellBits-1:0] dmem [StackDepth];
  logic [CellBits-1:0] rmem [StackDepth];

  logic [dcsu_pkg::ActW-1:0] act_q;
  logic [CellBits-1:0]       val_q;
  logic                      err_q;
  logic [DepW-1:0]           dd_q, rd_q;
  logic [CellBits-1:0]       a_q [6];
  logic [CellBits-1:0]       ra_q [2];
  logic [CellBits-1:0]       r_q [6];
  logic [SW-1:0]             k_q;
  logic                      cap_v_q;
  logic [SW-1:0]             cap_i_q;
  logic [CellBits-1:0]       drd_q, rrd_q;
  logic                      out_valid_q;
  logic [CellBits-1:0]       top_q;
  logic                      oerr_q;
  logic [dcsu_pkg::CountW-1:0] odc_q, orc_q;

  logic [SW-1:0] need, prod, load_len, store_len;
  logic          is_rget, is_tor, is_rfrom, valid_act, popped;
  logic [DepW:0] ddx, rdx, needx, prodx, depx;
  logic          under, over, error_now;
  logic [DepW-1:0] base;

  assign need      = dcsu_pkg::need_of(act_q);
  assign prod      = dcsu_pkg::prod_of(act_q);
  assign is_tor    = (act_q == dcsu_pkg::ACT_2TOR);
  assign is_rfrom  = (act_q == dcsu_pkg::ACT_2RFROM);
  assign is_rget   = is_rfrom || (act_q == dcsu_pkg::ACT_2RFETCH);
  assign valid_act = (act_q <= dcsu_pkg::ACT_D2DIV);
  assign popped    = (act_q == dcsu_pkg::ACT_POP) && !err_q;
  assign load_len  = is_rget ? SW'(2) : need;
  assign store_len = is_tor ? SW'(2) : prod;

  assign ddx   = {1'b0, dd_q};
  assign rdx   = {1'b0, rd_q};
  assign needx = (DepW+1)'(need);
  assign prodx = (DepW+1)'(prod);
  assign depx  = (DepW+1)'(StackDepth);
  assign under = (ddx < needx) || (is_rget && (rdx < (DepW+1)'(2)));
  assign over  = (ddx + prodx > depx + needx) || (is_tor && (rdx + (DepW+1)'(2) > depx));
  assign error_now = valid_act && (under || over);
  assign base  = dd_q - DepW'(need);

  assign sts_o.skip       = !valid_act || under || over;
  assign sts_o.load_done  = (k_q >= load_len) && !cap_v_q;
  assign sts_o.store_done = (k_q >= store_len);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // data and return memory addressing
  logic            issue, d_rd_en, r_rd_en, d_wr_en, r_wr_en;
  logic [AddrW-1:0] d_raddr, r_raddr, d_waddr, r_waddr;
  logic [DepW-1:0]  d_rtmp, r_rtmp, d_wtmp, r_wtmp;
  logic [CellBits-1:0] d_wdata, r_wdata;

  assign issue   = cmd_i.load && (k_q < load_len);
  assign d_rd_en = (issue && (k_q < need)) || cmd_i.top;
  assign r_rd_en = issue && is_rget;
  assign d_rtmp  = cmd_i.top ? dd_q - DepW'(1) : dd_q - DepW'(1) - DepW'(k_q);
  assign r_rtmp  = rd_q - DepW'(2) + DepW'(k_q);
  assign d_raddr = AddrW'(d_rtmp);
  assign r_raddr = AddrW'(r_rtmp);

  assign d_wr_en = cmd_i.store && (k_q < prod);
  assign r_wr_en = cmd_i.store && is_tor && (k_q < SW'(2));
  assign d_wtmp  = base + DepW'(k_q);
  assign r_wtmp  = rd_q + DepW'(k_q);
  assign d_waddr = AddrW'(d_wtmp);
  assign r_waddr = AddrW'(r_wtmp);
  assign d_wdata = (k_q < SW'(6)) ? r_q[k_q] : '0;
  assign r_wdata = (k_q == '0) ? a_q[1] : a_q[0];

  always_ff @(posedge clk_i) begin
    if (d_wr_en) dmem[d_waddr] <= d_wdata;
    if (d_rd_en) drd_q <= dmem[d_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (r_wr_en) rmem[r_waddr] <= r_wdata;
    if (r_rd_en) rrd_q <= rmem[r_raddr];
  end

  // word execution
  logic [DW-1:0] d1, d2, dsum, ddif, dneg, dres;
  logic          lt, eq, sel1;
  logic [CellBits-1:0] res [6];
  logic [CellBits-1:0] ones, zero_c;

  assign ones   = '1;
  assign zero_c = '0;
  assign d1   = {a_q[2], a_q[3]};
  assign d2   = {a_q[0], a_q[1]};
  assign dsum = d1 + d2;
  assign ddif = d1 - d2;
  assign dneg = ~d2 + DW'(1);
  assign lt   = $signed(d1) < $signed(d2);
  assign eq   = (d1 == d2);
  assign sel1 = (act_q == dcsu_pkg::ACT_DMAX) ? !lt : (lt || eq);

  always_comb begin
    dres = '0;
    for (int i = 0; i < 6; i++) res[i] = '0;
    case (act_q)
      dcsu_pkg::ACT_PUSH: res[0] = val_q;
      dcsu_pkg::ACT_STOD: begin
        res[0] = a_q[0];
        res[1] = a_q[0][CellBits-1] ? ones : zero_c;
      end
      dcsu_pkg::ACT_DPLUS:  dres = dsum;
      dcsu_pkg::ACT_DMINUS: dres = ddif;
      dcsu_pkg::ACT_DNEG:   dres = dneg;
      dcsu_pkg::ACT_DABS:   dres = a_q[0][CellBits-1] ? dneg : d2;
      dcsu_pkg::ACT_DMAX, dcsu_pkg::ACT_DMIN: dres = sel1 ? d1 : d2;
      dcsu_pkg::ACT_DLT: res[0] = lt ? ones : zero_c;
      dcsu_pkg::ACT_DEQ: res[0] = eq ? ones : zero_c;
      dcsu_pkg::ACT_2DUP: begin
        res[0] = a_q[1]; res[1] = a_q[0]; res[2] = a_q[1]; res[3] = a_q[0];
      end
      dcsu_pkg::ACT_2SWAP: begin
        res[0] = a_q[1]; res[1] = a_q[0]; res[2] = a_q[3]; res[3] = a_q[2];
      end
      dcsu_pkg::ACT_2OVER: begin
        res[0] = a_q[3]; res[1] = a_q[2]; res[2] = a_q[1]; res[3] = a_q[0];
        res[4] = a_q[3]; res[5] = a_q[2];
      end
      dcsu_pkg::ACT_2ROT: begin
        res[0] = a_q[3]; res[1] = a_q[2]; res[2] = a_q[1]; res[3] = a_q[0];
        res[4] = a_q[5]; res[5] = a_q[4];
      end
      dcsu_pkg::ACT_2RFROM, dcsu_pkg::ACT_2RFETCH: begin
        res[0] = ra_q[0]; res[1] = ra_q[1];
      end
      dcsu_pkg::ACT_D0EQ: res[0] = (d2 == '0) ? ones : zero_c;
      dcsu_pkg::ACT_D0LT: res[0] = a_q[0][CellBits-1] ? ones : zero_c;
      dcsu_pkg::ACT_D2MUL: dres = {d2[DW-2:0], 1'b0};
      dcsu_pkg::ACT_D2DIV: dres = {d2[DW-1], d2[DW-1:1]};
      default: dres = '0;
    endcase
    case (act_q)
      dcsu_pkg::ACT_DPLUS, dcsu_pkg::ACT_DMINUS, dcsu_pkg::ACT_DNEG,
      dcsu_pkg::ACT_DABS, dcsu_pkg::ACT_DMAX, dcsu_pkg::ACT_DMIN,
      dcsu_pkg::ACT_D2MUL, dcsu_pkg::ACT_D2DIV: begin
        res[0] = dres[CellBits-1:0];
        res[1] = dres[DW-1:CellBits];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q <= action_i;
      val_q <= push_value_i;
    end
    if (cmd_i.check) err_q <= error_now;
    if (cap_v_q) begin
      if (cap_i_q < SW'(6)) a_q[cap_i_q] <= drd_q;
      ra_q[cap_i_q[0]] <= rrd_q;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < 6; i++) r_q[i] <= res[i];
    end
    if (cmd_i.finish) begin
      top_q  <= popped ? a_q[0] : ((dd_q == '0) ? '0 : drd_q);
      oerr_q <= err_q;
      odc_q  <= dcsu_pkg::CountW'(dd_q);
      orc_q  <= dcsu_pkg::CountW'(rd_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dd_q        <= '0;
      rd_q        <= '0;
      k_q         <= '0;
      cap_v_q     <= 1'b0;
      cap_i_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cap_v_q <= issue;
      cap_i_q <= k_q;
      if (cmd_i.check || cmd_i.exec) begin
        k_q <= '0;
      end else if (issue || (cmd_i.store && !sts_o.store_done)) begin
        k_q <= k_q + SW'(1);
      end
      // commit depths once every cell is written
      if (cmd_i.store && sts_o.store_done) begin
        dd_q <= base + DepW'(prod);
        if (is_tor)   rd_q <= rd_q + DepW'(2);
        if (is_rfrom) rd_q <= rd_q - DepW'(2);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign top_value_o    = top_q;
  assign error_flag_o   = oerr_q;
  assign data_count_o   = odc_q;
  assign return_count_o = orc_q;

`ifndef SYNTHESIS
  a_dd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddx <= depx) else $error("data depth beyond stack size");
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdx <= depx) else $error("return depth beyond stack size");
  a_skip_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.check && sts_o.skip) |=> ($stable(dd_q) && $stable(rd_q)))
    else $error("rejected word changed a stack depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && out_valid_q) |-> out_ready_i)
    else $error("result overwrote an untaken transaction");
`endif

endmodule

>>> bench/double_cell_stack_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_cell_stack_unit_tb
// Self-checking bench for the double-cell stack unit: every word runs against
// a mirror of both stacks, with underflow, overflow and random word streams,
// under varying idle and stall on both sides of the handshake.
// ----------------------------------------------------------------------------
module double_cell_stack_unit_tb;

  localparam int Depth  = dcsu_pkg::StackDepthDef;
  localparam int ActW   = dcsu_pkg::ActW;
  localparam int CountW = dcsu_pkg::CountW;

  typedef logic [63:0] cell_t;

  typedef struct {
    cell_t            top;
    logic             err;
    logic [CountW-1:0] dcnt;
    logic [CountW-1:0] rcnt;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [ActW-1:0]      action_i = dcsu_pkg::ACT_PUSH;
  logic signed [63:0]   push_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [63:0]   top_value_o;
  logic                 error_flag_o;
  logic [CountW-1:0]    data_count_o;
  logic [CountW-1:0]    return_count_o;

  cell_t    data_mirror[Depth];
  cell_t    ret_mirror[Depth];
  int       data_lvl = 0;
  int       ret_lvl = 0;
  outcome_t pending_results[$];
  int       mismatches = 0;
  int       tx_idle_pct = 16;
  int       rx_idle_pct = 53;

  double_cell_stack_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // Apply one word to the mirrored stacks and return what the unit must report.
  function automatic outcome_t apply_word(logic [ActW-1:0] act, cell_t val);
    outcome_t     o;
    cell_t        a[6];
    cell_t        r[6];
    int           need, nr;
    logic         err, popped;
    cell_t        popval;
    logic [127:0] d1, d2, dr;
    need = 0; nr = 0; err = 0; popped = 0; popval = '0;
    foreach (a[k]) begin
      a[k] = '0;
      r[k] = '0;
    end
    if (act <= dcsu_pkg::ACT_D2DIV) begin
      case (act)
        dcsu_pkg::ACT_PUSH, dcsu_pkg::ACT_2RFROM, dcsu_pkg::ACT_2RFETCH: need = 0;
        dcsu_pkg::ACT_POP, dcsu_pkg::ACT_STOD: need = 1;
        dcsu_pkg::ACT_DPLUS, dcsu_pkg::ACT_DMINUS, dcsu_pkg::ACT_DMAX,
        dcsu_pkg::ACT_DMIN, dcsu_pkg::ACT_DLT, dcsu_pkg::ACT_DEQ,
        dcsu_pkg::ACT_2SWAP, dcsu_pkg::ACT_2OVER: need = 4;
        dcsu_pkg::ACT_2ROT: need = 6;
        default: need = 2;
      endcase
      if (data_lvl < need) err = 1;
      if (act == dcsu_pkg::ACT_2TOR && ret_lvl + 2 > Depth) err = 1;
      if ((act == dcsu_pkg::ACT_2RFROM || act == dcsu_pkg::ACT_2RFETCH) && ret_lvl < 2)
        err = 1;
    end
    if (act <= dcsu_pkg::ACT_D2DIV && !err) begin
      for (int k = 0; k < need; k++) a[k] = data_mirror[data_lvl-1-k];
      d1 = {a[2], a[3]};
      d2 = {a[0], a[1]};
      case (act)
        dcsu_pkg::ACT_PUSH: begin
          r[0] = val; nr = 1;
        end
        dcsu_pkg::ACT_POP: begin
          popped = 1; popval = a[0];
        end
        dcsu_pkg::ACT_STOD: begin
          r[0] = a[0]; r[1] = {64{a[0][63]}}; nr = 2;
        end
        dcsu_pkg::ACT_DPLUS, dcsu_pkg::ACT_DMINUS, dcsu_pkg::ACT_DNEG,
        dcsu_pkg::ACT_DABS, dcsu_pkg::ACT_D2MUL, dcsu_pkg::ACT_D2DIV: begin
          case (act)
            dcsu_pkg::ACT_DPLUS:  dr = d1 + d2;
            dcsu_pkg::ACT_DMINUS: dr = d1 - d2;
            dcsu_pkg::ACT_DNEG:   dr = -d2;
            dcsu_pkg::ACT_DABS:   dr = d2[127] ? -d2 : d2;
            dcsu_pkg::ACT_D2MUL:  dr = d2 << 1;
            default:              dr = $signed(d2) >>> 1;
          endcase
          r[0] = dr[63:0]; r[1] = dr[127:64]; nr = 2;
        end
        dcsu_pkg::ACT_DMAX, dcsu_pkg::ACT_DMIN: begin
          if ((act == dcsu_pkg::ACT_DMAX) ? ($signed(d1) >= $signed(d2))
                                          : ($signed(d1) <= $signed(d2))) begin
            r[0] = a[3]; r[1] = a[2];
          end else begin
            r[0] = a[1]; r[1] = a[0];
          end
          nr = 2;
        end
        dcsu_pkg::ACT_DLT: begin
          r[0] = ($signed(d1) < $signed(d2)) ? '1 : '0; nr = 1;
        end
        dcsu_pkg::ACT_DEQ: begin
          r[0] = (d1 == d2) ? '1 : '0; nr = 1;
        end
        dcsu_pkg::ACT_2DUP: begin
          r[0] = a[1]; r[1] = a[0]; r[2] = a[1]; r[3] = a[0]; nr = 4;
        end
        dcsu_pkg::ACT_2SWAP: begin
          r[0] = a[1]; r[1] = a[0]; r[2] = a[3]; r[3] = a[2]; nr = 4;
        end
        dcsu_pkg::ACT_2OVER, dcsu_pkg::ACT_2ROT: begin
          r[0] = a[3]; r[1] = a[2]; r[2] = a[1]; r[3] = a[0];
          r[4] = (act == dcsu_pkg::ACT_2OVER) ? a[3] : a[5];
          r[5] = (act == dcsu_pkg::ACT_2OVER) ? a[2] : a[4];
          nr = 6;
        end
        dcsu_pkg::ACT_2RFROM, dcsu_pkg::ACT_2RFETCH: begin
          r[0] = ret_mirror[ret_lvl-2]; r[1] = ret_mirror[ret_lvl-1]; nr = 2;
        end
        dcsu_pkg::ACT_D0EQ: begin
          r[0] = (d2 == '0) ? '1 : '0; nr = 1;
        end
        dcsu_pkg::ACT_D0LT: begin
          r[0] = a[0][63] ? '1 : '0; nr = 1;
        end
        default: ; // 2DROP, 2>R produce no data cells
      endcase
      if (data_lvl - need + nr > Depth) begin
        err = 1;
        popped = 0;
      end else begin
        data_lvl -= need;
        for (int k = 0; k < nr; k++) data_mirror[data_lvl++] = r[k];
        if (act == dcsu_pkg::ACT_2TOR) begin
          ret_mirror[ret_lvl++] = a[1];
          ret_mirror[ret_lvl++] = a[0];
        end else if (act == dcsu_pkg::ACT_2RFROM) begin
          ret_lvl -= 2;
        end
      end
    end
    o.top  = popped ? popval : (data_lvl > 0 ? data_mirror[data_lvl-1] : '0);
    o.err  = err;
    o.dcnt = data_lvl[CountW-1:0];
    o.rcnt = ret_lvl[CountW-1:0];
    return o;
  endfunction

  // Send one word; valid stays high afterwards until the next call or the end.
  task automatic send_word(logic [ActW-1:0] act, cell_t val = '0);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    push_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(apply_word(act, val));
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= (rx_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction");
      end else begin
        exp_o = pending_results.pop_front();
        if (top_value_o !== exp_o.top || error_flag_o !== exp_o.err ||
            data_count_o !== exp_o.dcnt || return_count_o !== exp_o.rcnt) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp top=%h err=%b d=%0d r=%0d, got top=%h err=%b d=%0d r=%0d",
                     exp_o.top, exp_o.err, exp_o.dcnt, exp_o.rcnt,
                     top_value_o, error_flag_o, data_count_o, return_count_o);
        end
      end
    end
  end

  function automatic cell_t pick_cell();
    case ($urandom_range(7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return '0;
      3: return '1;
      4: return cell_t'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // empty both stacks, dropping data when the data stack has no room left
  task automatic drain_stacks();
    while (ret_lvl >= 2) begin
      if (data_lvl > Depth - 2) send_word(dcsu_pkg::ACT_2DROP);
      else send_word(dcsu_pkg::ACT_2RFROM);
    end
    while (data_lvl >= 2) send_word(dcsu_pkg::ACT_2DROP);
    if (data_lvl > 0) send_word(dcsu_pkg::ACT_POP);
  endtask

  // every word but push on empty stacks, plus the unused codes
  task automatic test_underflow();
    for (int c = 0; c < 32; c++) if (c != dcsu_pkg::ACT_PUSH) send_word(c[ActW-1:0]);
  endtask

  // each word but push and pop once on a freshly loaded stack
  task automatic test_words();
    cell_t ext[4] = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '0, '1};
    for (int c = dcsu_pkg::ACT_STOD; c <= dcsu_pkg::ACT_D2DIV; c++) begin
      for (int k = 0; k < 6; k++) send_word(dcsu_pkg::ACT_PUSH, ext[(c + k) % 4]);
      send_word(c[ActW-1:0]);
      if (c == dcsu_pkg::ACT_2TOR) send_word(dcsu_pkg::ACT_2RFETCH);
      drain_stacks();
    end
  endtask

  // fill both stacks to the brim and try to go past
  task automatic test_overflow();
    for (int k = 0; k < 2; k++) send_word(dcsu_pkg::ACT_PUSH, pick_cell());
    while (data_lvl < Depth) begin
      if (data_lvl >= 4 && $urandom_range(1) == 1) send_word(dcsu_pkg::ACT_2OVER);
      else send_word(dcsu_pkg::ACT_2DUP);
    end
    send_word(dcsu_pkg::ACT_PUSH, '1);
    send_word(dcsu_pkg::ACT_2DUP);
    send_word(dcsu_pkg::ACT_STOD);
    send_word(dcsu_pkg::ACT_2RFETCH);
    for (int k = 0; k < Depth / 2; k++) send_word(dcsu_pkg::ACT_2TOR);
    for (int k = 0; k < 2; k++) send_word(dcsu_pkg::ACT_PUSH, pick_cell());
    send_word(dcsu_pkg::ACT_2TOR);
    send_word(dcsu_pkg::ACT_2RFETCH);
    send_word(dcsu_pkg::ACT_2RFROM);
  endtask

  // mostly meaningful word streams on a shallow stack, some unused codes
  task automatic test_random(int tx_pct, int rx_pct, int n);
    int c;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n; i++) begin
      if (data_lvl < 6 || $urandom_range(3) == 0) c = dcsu_pkg::ACT_PUSH;
      else if (data_lvl > 14 && $urandom_range(1)) c = dcsu_pkg::ACT_2DROP;
      else if (ret_lvl > 10 && $urandom_range(1)) c = dcsu_pkg::ACT_2RFROM;
      else if ($urandom_range(19) == 0) c = $urandom_range(31);
      else c = $urandom_range(dcsu_pkg::ACT_POP, dcsu_pkg::ACT_D2DIV);
      send_word(c[ActW-1:0], pick_cell());
    end
    drain_stacks();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_underflow();
    test_words();
    test_random(16, 53, 40);
    test_random(53, 16, 40);
    test_random(0, 0, 40);
    test_overflow();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
